// ===== hw/rtl/jkve_pkg.sv =====
// Shared constants and helpers for the key/value extractor.
// Holds the key text, its border table and the key matcher step function.
// Depends on nothing; jkve_front and jkve_back import it.
`default_nettype none

package jkve_pkg;

	localparam int KEY_LEN = 9;
	localparam logic [7:0] QUOTE = 8'h22;
	localparam int OUT_DEPTH = 4;

	// "onion":"
	localparam logic [7:0] KEY_CHARS [KEY_LEN] = '{
		8'h22, 8'h6f, 8'h6e, 8'h69, 8'h6f, 8'h6e, 8'h22, 8'h3a, 8'h22
	};

	// longest proper border of the first k key characters
	localparam logic [3:0] KEY_BORDER [KEY_LEN] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd0
	};

	// One step of the prefix matcher: fall back along the border chain, then extend.
	function automatic logic [3:0] key_advance(input logic [3:0] pos, input logic [7:0] ch);
		logic [3:0] k;
		logic       done;
		k    = (pos >= 4'(KEY_LEN)) ? 4'd0 : pos;
		done = 1'b0;
		for (int s = 0; s < KEY_LEN - 1; s++) begin
			if (!done) begin
				if (k == 4'd0 || KEY_CHARS[k] == ch) begin
					done = 1'b1;
				end else begin
					k = KEY_BORDER[k];
				end
			end
		end
		if (KEY_CHARS[k] == ch) begin
			k = k + 4'd1;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jkve_value_ram.sv =====
// Two-bank value store: one write port, one read port with registered data.
// Depends on nothing beyond its parameters.
`default_nettype none

module jkve_value_ram #(
	parameter int ADDR_W = 7
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [7:0]        wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [7:0]        rd_data
);

	logic [7:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/jkve_front.sv =====
// Front end: key matcher and value capture into the current buffer bank.
// Depends on jkve_pkg; writes jkve_value_ram and pushes into jkve_job_queue.
`default_nettype none

module jkve_front #(
	parameter int VALUE_DEPTH = 64,
	parameter int AW          = 6,
	parameter int LW          = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_take,
	input  wire logic [7:0]    text_byte,
	input  wire logic          end_of_text,
	input  wire logic [6:0]    max_len,
	output      logic          wr_en,
	output      logic [AW:0]   wr_addr,
	output      logic [7:0]    wr_data,
	output      logic          job_push,
	output      logic          job_bank,
	output      logic [LW-1:0] job_len
);
	import jkve_pkg::*;

	localparam int CW = (LW > 7) ? LW : 7;

	logic [3:0]    key_pos_q;
	logic          capturing_q;
	logic [LW-1:0] cap_len_q;
	logic          bank_q;
	logic [3:0]    key_nxt;
	logic          is_quote;
	logic          len_ok;

	assign key_nxt  = key_advance(key_pos_q, text_byte);
	assign is_quote = (text_byte == QUOTE);
	assign len_ok   = (cap_len_q != '0)
		&& (CW'(cap_len_q) <= CW'(max_len))
		&& (cap_len_q <= LW'(VALUE_DEPTH));

	assign wr_en    = item_take && !end_of_text && capturing_q && !is_quote
		&& (cap_len_q < LW'(VALUE_DEPTH));
	assign wr_addr  = {bank_q, cap_len_q[AW-1:0]};
	assign wr_data  = text_byte;
	assign job_push = item_take && !end_of_text && capturing_q && is_quote && len_ok;
	assign job_bank = bank_q;
	assign job_len  = cap_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q   <= '0;
			capturing_q <= 1'b0;
			cap_len_q   <= '0;
			bank_q      <= 1'b0;
		end else if (item_take) begin
			if (end_of_text) begin
				key_pos_q   <= '0;
				capturing_q <= 1'b0;
				cap_len_q   <= '0;
			end else if (capturing_q) begin
				if (is_quote) begin
					capturing_q <= 1'b0;
					cap_len_q   <= '0;
					key_pos_q   <= '0;
					if (len_ok) begin
						bank_q <= !bank_q;
					end
				end else if (cap_len_q <= LW'(VALUE_DEPTH)) begin
					cap_len_q <= cap_len_q + LW'(1);
				end
			end else if (key_nxt == 4'(KEY_LEN)) begin
				key_pos_q   <= '0;
				capturing_q <= 1'b1;
				cap_len_q   <= '0;
			end else begin
				key_pos_q <= key_nxt;
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		key_pos_q < 4'(KEY_LEN))
		else $error("key position out of range");

	a_capture_idle_matcher: assert property (@(posedge clk) disable iff (!arst_n)
		capturing_q |-> key_pos_q == 4'd0)
		else $error("matcher not parked during capture");

endmodule

`default_nettype wire

// ===== hw/rtl/jkve_job_queue.sv =====
// Two-entry queue of finished values (bank and length) between front and back.
// Depends on nothing beyond its parameters.
`default_nettype none

module jkve_job_queue #(
	parameter int LW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          push_bank,
	input  wire logic [LW-1:0] push_len,
	input  wire logic          pop,
	output      logic          full,
	output      logic          head_valid,
	output      logic          head_bank,
	output      logic [LW-1:0] head_len
);

	logic          bank_q [2];
	logic [LW-1:0] len_q  [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_bank  = bank_q[rd_ptr_q];
	assign head_len   = len_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			bank_q[wr_ptr_q] <= push_bank;
			len_q[wr_ptr_q]  <= push_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue overflow");

endmodule

`default_nettype wire

// ===== hw/rtl/jkve_back.sv =====
// Back end: reads a finished value out of its bank and feeds the result queue.
// Depends on jkve_pkg; reads jkve_value_ram and pops jkve_job_queue.
`default_nettype none

module jkve_back #(
	parameter int AW = 6,
	parameter int LW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  wire logic          job_bank,
	input  wire logic [LW-1:0] job_len,
	output      logic          job_pop,
	output      logic          rd_en,
	output      logic [AW:0]   rd_addr,
	input  wire logic [7:0]    rd_data,
	output      logic          empty,
	input  wire logic          pop,
	output      logic [7:0]    value_byte,
	output      logic          value_last
);
	import jkve_pkg::*;

	localparam int PW = $clog2(OUT_DEPTH);
	localparam int CNW = $clog2(OUT_DEPTH + 1);

	logic [LW-1:0]  idx_q;
	logic           valid_s1;
	logic           last_s1;
	logic [7:0]     obyte_q [OUT_DEPTH];
	logic           olast_q [OUT_DEPTH];
	logic [PW-1:0]  owr_q;
	logic [PW-1:0]  ord_q;
	logic [CNW-1:0] ocnt_q;
	logic           is_last;
	logic           opop;

	// Issue a read only when the result queue has room for it and the one in flight.
	assign rd_en   = job_valid && ((CNW+1)'(ocnt_q) + (CNW+1)'(valid_s1)
		< (CNW+1)'(OUT_DEPTH));
	assign rd_addr = {job_bank, idx_q[AW-1:0]};
	assign is_last = (idx_q == job_len - LW'(1));
	assign job_pop = rd_en && is_last;

	assign empty      = (ocnt_q == '0);
	assign opop       = pop && !empty;
	assign value_byte = obyte_q[ord_q];
	assign value_last = olast_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (rd_en) begin
				idx_q <= is_last ? '0 : idx_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			last_s1 <= is_last;
		end
		if (valid_s1) begin
			obyte_q[owr_q] <= rd_data;
			olast_q[owr_q] <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (valid_s1) begin
				owr_q <= owr_q + PW'(1);
			end
			if (opop) begin
				ord_q <= ord_q + PW'(1);
			end
			ocnt_q <= ocnt_q + CNW'(valid_s1) - CNW'(opop);
		end
	end

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ocnt_q < CNW'(OUT_DEPTH))
		else $error("result queue overflow");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> idx_q < job_len)
		else $error("read index past value length");

endmodule

`default_nettype wire

// ===== hw/rtl/json_key_value_extractor.sv =====
// Top level of the streaming key/value extractor: front, job queue, back, store.
// Depends on jkve_pkg, jkve_value_ram, jkve_front, jkve_job_queue, jkve_back.
//
//   channel   handshake        payload                    transfer when
//   input     push / full      text_byte, end_of_text     push && !full
//   result    empty / pop      value_byte, value_last     pop && !empty
//   config    cfg_we           cfg_data (max_value_len)   cfg_we
//
// Cycles: the front takes one text byte every cycle while full is low. A
// value is drained by the back at up to one byte a cycle through a one-stage
// store read and a four-entry result queue, overlapping with later text.
// full rises only when two finished values both wait to be drained, the
// limit set by the two banks of the value store; it falls once the older
// value's last byte has been read. Reset clears all control state at once;
// there is no clearing pass. A stalled result side holds the result queue
// and in turn the back, never the front, until both banks are taken.
`default_nettype none

module json_key_value_extractor #(
	parameter int VALUE_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output      logic       full,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	output      logic       empty,
	input  wire logic       pop,
	output      logic [7:0] value_byte,
	output      logic       value_last,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_data
);

	// Store index bits per bank, and a length field wide enough for "too long".
	localparam int AW = $clog2(VALUE_DEPTH);
	localparam int LW = $clog2(VALUE_DEPTH + 2);

	logic [6:0]    max_len_q;
	logic          item_take;
	logic          wr_en;
	logic [AW:0]   wr_addr;
	logic [7:0]    wr_data;
	logic          job_push;
	logic          job_bank;
	logic [LW-1:0] job_len;
	logic          job_pop;
	logic          head_valid;
	logic          head_bank;
	logic [LW-1:0] head_len;
	logic          rd_en;
	logic [AW:0]   rd_addr;
	logic [7:0]    rd_data;

	assign item_take = push && !full;

	// Hold the length limit; the user must write it only while the block is idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 7'd62;
		end else if (cfg_we) begin
			max_len_q <= cfg_data;
		end
	end

	jkve_front #(
		.VALUE_DEPTH(VALUE_DEPTH),
		.AW         (AW),
		.LW         (LW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_take  (item_take),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.max_len    (max_len_q),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.job_push   (job_push),
		.job_bank   (job_bank),
		.job_len    (job_len)
	);

	jkve_value_ram #(
		.ADDR_W(AW + 1)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Stall the input side while both banks hold undrained values.
	jkve_job_queue #(
		.LW(LW)
	) u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_bank (job_bank),
		.push_len  (job_len),
		.pop       (job_pop),
		.full      (full),
		.head_valid(head_valid),
		.head_bank (head_bank),
		.head_len  (head_len)
	);

	jkve_back #(
		.AW(AW),
		.LW(LW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job_bank  (head_bank),
		.job_len   (head_len),
		.job_pop   (job_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.empty     (empty),
		.pop       (pop),
		.value_byte(value_byte),
		.value_last(value_last)
	);

endmodule

`default_nettype wire

// ===== dv/json_key_value_extractor_tb.sv =====
// Self-checking testbench for json_key_value_extractor: feeds text bytes through the
// push/full queue, predicts each value transfer with its own key scanner and checks
// every popped byte in order. Depends only on the extractor RTL and its package.

module json_key_value_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_DEPTH = 64;
	localparam int KEY_LEN = 9;
	localparam logic [7:0] QUOTE = 8'h22;
	// "onion":" packed, first character in the top byte
	localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "\"onion\":\"";
	localparam logic [6:0] MAX_LEN_RESET = 7'd62;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_ITEMS_PER_PHASE = 1;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} value_beat_t;

	// Clock, reset and block ports; every input is known from time zero
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] value_byte;
	logic       value_last;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_data = 7'd0;

	// Stimulus and expectation stores
	text_item_t  text_pending[$];
	value_beat_t values_due[$];
	int          mismatches = 0;

	// Handshake bookkeeping
	logic in_taken = 1'b0;
	int   tx_wait = 0;
	int   rx_wait = 0;
	int   rx_hold = 0;
	int   rx_hold_ask = 0;
	int   rx_hold_seen = 0;
	logic tx_steady = 1'b0;
	logic rx_steady = 1'b0;

	// Scanner state, kept in step with the block
	int         scan_pos = 0;
	logic       in_value = 1'b0;
	int         value_len = 0;
	logic [7:0] value_store [VALUE_DEPTH];
	logic [6:0] max_len = MAX_LEN_RESET;

	json_key_value_extractor #(
		.VALUE_DEPTH(VALUE_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.empty      (empty),
		.pop        (pop),
		.value_byte (value_byte),
		.value_last (value_last),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] key_char(input int j);
		return KEY_TEXT[8*(KEY_LEN-1-j) +: 8];
	endfunction

	// Next match length: the longest suffix of (matched prefix, ch) that is also a
	// prefix of the key. A full match restarts from nothing.
	function automatic int key_next(input int k, input logic [7:0] ch);
		logic [7:0] seen [KEY_LEN];
		int         n;
		int         len;
		logic       ok;
		if (k >= KEY_LEN) k = 0;
		for (int j = 0; j < k; j++) seen[j] = key_char(j);
		seen[k] = ch;
		n = k + 1;
		for (len = n; len > 0; len--) begin
			ok = 1'b1;
			for (int j = 0; j < len; j++) begin
				if (seen[n-len+j] != key_char(j)) ok = 1'b0;
			end
			if (ok) return len;
		end
		return 0;
	endfunction

	// Advance the scanner by one accepted text item and queue any value it closes.
	task automatic scan_byte(input logic [7:0] ch, input logic eot);
		int limit;
		if (eot) begin
			// end of text: drop any open value, restart the search
			scan_pos = 0;
			in_value = 1'b0;
			value_len = 0;
		end else if (in_value) begin
			if (ch == QUOTE) begin
				limit = (max_len > VALUE_DEPTH) ? VALUE_DEPTH : int'(max_len);
				if (value_len != 0 && value_len <= limit) begin
					for (int i = 0; i < value_len; i++)
						values_due.push_back('{data: value_store[i], last: (i == value_len - 1)});
				end
				// the closing quote never reaches the matcher
				in_value = 1'b0;
				value_len = 0;
				scan_pos = 0;
			end else begin
				if (value_len < VALUE_DEPTH) value_store[value_len] = ch;
				// saturate one past the depth: that alone marks the value too long
				if (value_len <= VALUE_DEPTH) value_len++;
			end
		end else begin
			scan_pos = key_next(scan_pos, ch);
			if (scan_pos == KEY_LEN) begin
				scan_pos = 0;
				in_value = 1'b1;
				value_len = 0;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input value_beat_t want,
			input value_beat_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t ns mismatch (%s): expected byte %02h last %0b, got byte %02h last %0b",
				$time, what, want.data, want.last, got.data, got.last);
		end
	endtask

	// Mostly no gap, some short ones, a few long ones.
	function automatic int pick_gap(input logic steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Sample everything at the rising edge: register writes, input transfers into
	// the scanner, result transfers against the oldest expectation.
	always @(posedge clk) begin : monitor
		value_beat_t want;
		value_beat_t got;
		if (arst_n) begin
			if (cfg_we) max_len = cfg_data;
			in_taken <= push && !full;
			if (push && !full) scan_byte(text_byte, end_of_text);
			if (pop && !empty) begin
				got = '{data: value_byte, last: value_last};
				if (values_due.size() == 0) begin
					report_mismatch("no value due", '0, got);
				end else begin
					want = values_due.pop_front();
					if (got.data !== want.data || got.last !== want.last)
						report_mismatch("value transfer", want, got);
				end
			end
		end
	end

	// Sender: change inputs at the falling edge. Hold the item while it waits for a
	// transfer; once taken, idle for the chosen gap or offer the next one at once.
	always @(negedge clk) begin : driver
		text_item_t nxt;
		if (arst_n && (!push || in_taken)) begin
			if (tx_wait > 0) begin
				tx_wait <= tx_wait - 1;
				push <= 1'b0;
			end else if (text_pending.size() != 0) begin
				nxt = text_pending.pop_front();
				text_byte <= nxt.ch;
				end_of_text <= nxt.eot;
				push <= 1'b1;
				tx_wait <= pick_gap(tx_steady);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: random pop gaps, plus a long hold-off on request so that both value
	// banks fill and full stalls the sender.
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (rx_hold > 0) begin
				pop <= 1'b0;
				rx_hold <= rx_hold - 1;
			end else if (rx_hold_seen != rx_hold_ask) begin
				pop <= 1'b0;
				rx_hold <= RX_HOLD_CYCLES;
				rx_hold_seen <= rx_hold_ask;
			end else if (rx_wait > 0) begin
				pop <= 1'b0;
				rx_wait <= rx_wait - 1;
			end else begin
				pop <= 1'b1;
				rx_wait <= pick_gap(rx_steady);
			end
		end
	end

	task automatic add_byte(input logic [7:0] b);
		text_pending.push_back('{ch: b, eot: 1'b0});
	endtask

	task automatic add_eot();
		text_pending.push_back('{ch: 8'($urandom_range(0, 255)), eot: 1'b1});
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	task automatic add_key();
		for (int j = 0; j < KEY_LEN; j++) add_byte(key_char(j));
	endtask

	function automatic logic [7:0] value_char();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == QUOTE);
		return b;
	endfunction

	// Key, len value bytes, closing quote.
	task automatic add_value(input int len);
		add_key();
		for (int i = 0; i < len; i++) add_byte(value_char());
		add_byte(QUOTE);
	endtask

	// One random record: noise and near misses, then mostly a well-formed key and
	// value, sometimes cut short by end of text.
	task automatic add_record(input int lim_eff);
		int kind;
		int r;
		int len;
		kind = $urandom_range(0, 99);
		repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
		// near misses make the matcher fall back along the border
		if (kind < 15) add_text("\"onion\"");
		else if (kind < 25) add_text("\"oni");
		if (kind >= 92) begin
			add_text("\"onion\":");
			add_eot();
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 10) len = 0;
		else if (r < 18) len = lim_eff;
		else if (r < 24) len = lim_eff + 1;
		else if (r < 27) len = VALUE_DEPTH + 2;
		else len = $urandom_range(1, 6);
		add_key();
		for (int i = 0; i < len; i++) add_byte(value_char());
		if (kind >= 84) add_eot();
		else add_byte(QUOTE);
	endtask

	task automatic add_random(input int lim_eff);
		int start;
		start = text_pending.size();
		while (text_pending.size() - start < RANDOM_ITEMS_PER_PHASE) add_record(lim_eff);
	endtask

	// Wait for every item to go in and every value to come out, then let the block
	// settle; dropped values may still be in flight after the last transfer.
	task automatic wait_drained();
		do @(posedge clk); while (text_pending.size() != 0 || push || values_due.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [6:0] v);
		@(negedge clk);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int setting;
		int lim_eff;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, at the reset maximum: extreme value bytes; a closing quote that
		// must not start a new key match; an empty value; an unterminated value
		// dropped by end of text.
		add_key();
		add_byte(8'h00);
		add_byte(8'hff);
		add_byte(QUOTE);
		add_text("onion\":\"");
		add_value(0);
		add_key();
		add_byte(8'h71);
		add_eot();
		wait_drained();

		// Pressure: hold the receiver off while the sender streams short values back
		// to back, so that full rises and the input stalls.
		tx_steady = 1'b1;
		rx_hold_ask = rx_hold_ask + 1;
		repeat (4) add_value(3);
		wait_drained();
		tx_steady = 1'b0;

		// Sweep the maximum: smallest, depth, above depth (clamped), zero, random.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: setting = 1;
				1: setting = VALUE_DEPTH;
				2: setting = 127;
				3: setting = 0;
				default: setting = $urandom_range(2, VALUE_DEPTH - 1);
			endcase
			lim_eff = (setting > VALUE_DEPTH) ? VALUE_DEPTH : setting;
			tx_steady = (p == 3);
			rx_steady = (p == 1 || p == 3);
			write_max_len(7'(setting));
			add_random(lim_eff);
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/jkve_pkg.sv
hw/rtl/jkve_value_ram.sv
hw/rtl/jkve_front.sv
hw/rtl/jkve_job_queue.sv
hw/rtl/jkve_back.sv
hw/rtl/json_key_value_extractor.sv
dv/json_key_value_extractor_tb.sv
